// ----- rtl/drf_pkg.sv -----
// Shared constants for the dielectric refraction and Fresnel pipeline.
// Depends on nothing; used by drf_unitize and the top level.
package drf_pkg;

  localparam int DEF_COMPONENT_WIDTH = 16;
  localparam int FRAC_W = 30;
  localparam int UNIT_W = 32;
  localparam int ROOT_W = 31;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int QUO_W = 31;
  localparam int UNIT_NUM_W = 2 * FRAC_W + 1;
  localparam int UNIT_LAT = 4 + ROOT_W + 1 + QUO_W + 1;
  localparam int OUT_W = 16;

endpackage

// ----- rtl/drf_delay.sv -----
// Fixed-length enabled delay line for data that travels beside the arithmetic.
// Depends on nothing.
module drf_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < D; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[D-1];

endmodule

// ----- rtl/drf_isqrt.sv -----
// Pipelined floor integer square root, one result bit per stage.
// Depends on nothing.
module drf_isqrt #(
  parameter int IN_W = 62
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int RW = IN_W / 2;

  logic [RW+1:0]   rem_s  [RW];
  logic [RW-1:0]   root_s [RW];
  logic [IN_W-1:0] rad_s  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   cur_rem;
    logic [RW-1:0]   cur_root;
    logic [IN_W-1:0] cur_rad;
    logic [RW+3:0]   sh;
    logic [RW+3:0]   trial;
    logic            take;
    if (k == 0) begin : g_first
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_rad  = rad;
    end else begin : g_next
      assign cur_rem  = rem_s[k-1];
      assign cur_root = root_s[k-1];
      assign cur_rad  = rad_s[k-1];
    end
    assign sh    = {cur_rem, cur_rad[IN_W-1:IN_W-2]};
    assign trial = (RW+4)'({cur_root, 2'b01});
    assign take  = sh >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= take ? (RW+2)'(sh - trial) : (RW+2)'(sh);
        root_s[k] <= {cur_root[RW-2:0], take};
        rad_s[k]  <= cur_rad << 2;
      end
    end
  end

  assign root = root_s[RW-1];

endmodule

// ----- rtl/drf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in Q_W bits. Depends on nothing.
module drf_div #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 31,
  parameter int Q_W = 31
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [DEN_W-1:0] rem_s [Q_W];
  logic [Q_W-1:0]   lo_s  [Q_W];
  logic [Q_W-1:0]   quo_s [Q_W];
  logic [DEN_W-1:0] den_s [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] cur_rem;
    logic [Q_W-1:0]   cur_lo;
    logic [Q_W-1:0]   cur_quo;
    logic [DEN_W-1:0] cur_den;
    logic [DEN_W:0]   trial;
    logic             take;
    if (k == 0) begin : g_first
      assign cur_rem = DEN_W'(num[NUM_W-1:Q_W]);
      assign cur_lo  = num[Q_W-1:0];
      assign cur_quo = '0;
      assign cur_den = den;
    end else begin : g_next
      assign cur_rem = rem_s[k-1];
      assign cur_lo  = lo_s[k-1];
      assign cur_quo = quo_s[k-1];
      assign cur_den = den_s[k-1];
    end
    assign trial = {cur_rem, cur_lo[Q_W-1]};
    assign take  = trial >= {1'b0, cur_den};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= take ? DEN_W'(trial - {1'b0, cur_den}) : trial[DEN_W-1:0];
        lo_s[k]  <= cur_lo << 1;
        quo_s[k] <= {cur_quo[Q_W-2:0], take};
        den_s[k] <= cur_den;
      end
    end
  end

  assign quo = quo_s[Q_W-1];

endmodule

// ----- rtl/drf_unitize.sv -----
// Normalises a raw three-component vector to Q1.30 unit length.
// Depends on drf_pkg, drf_delay, drf_isqrt and drf_div.
module drf_unitize #(
  parameter int CW = drf_pkg::DEF_COMPONENT_WIDTH
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [CW-1:0]                vec  [3],
  output logic signed [drf_pkg::UNIT_W-1:0]   unit [3],
  output logic                                nz
);

  localparam int FW = drf_pkg::FRAC_W;
  localparam int PW = $clog2(CW);
  localparam int SIDE_W = 1 + 3 + 3 * FW;

  logic [CW-1:0]   mag1 [3];
  logic [2:0]      neg1;
  logic [CW-1:0]   orm;
  logic [PW-1:0]   lead;
  logic [FW-1:0]   norm_c [3];
  logic [FW-1:0]   norm2 [3];
  logic [2:0]      neg2;
  logic            nz2;
  logic [2*FW-1:0] sq3 [3];
  logic [drf_pkg::RAD_W-1:0] sum4;
  logic [SIDE_W-1:0] side_in;
  logic [SIDE_W-1:0] side_out;
  logic [drf_pkg::ROOT_W-1:0] len;
  logic [drf_pkg::UNIT_NUM_W-1:0] num5 [3];
  logic [drf_pkg::ROOT_W-1:0] den5;
  logic [3:0]      flg5;
  logic [3:0]      flg_q;
  logic [drf_pkg::QUO_W-1:0] quo [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= vec[i][CW-1] ? CW'(-vec[i]) : CW'(vec[i]);
        neg1[i] <= vec[i][CW-1];
      end
    end
  end

  always_comb begin
    logic [CW+FW-1:0] wide;
    orm  = mag1[0] | mag1[1] | mag1[2];
    lead = '0;
    for (int b = 0; b < CW; b++) begin
      if (orm[b]) begin
        lead = PW'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      wide      = {mag1[i], FW'(0)} >> (int'(lead) + 1);
      norm_c[i] = wide[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm2 <= norm_c;
      neg2  <= neg1;
      nz2   <= orm != '0;
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= (2*FW)'(norm2[i]) * (2*FW)'(norm2[i]);
      end
      sum4 <= drf_pkg::RAD_W'(sq3[0]) + drf_pkg::RAD_W'(sq3[1])
            + drf_pkg::RAD_W'(sq3[2]);
    end
  end

  assign side_in = {nz2, neg2, norm2[0], norm2[1], norm2[2]};

  drf_delay #(.W(SIDE_W), .D(2 + drf_pkg::ROOT_W)) u_side (
    .clk(clk), .en(en), .din(side_in), .dout(side_out)
  );

  drf_isqrt #(.IN_W(drf_pkg::RAD_W)) u_len (
    .clk(clk), .en(en), .rad(sum4), .root(len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num5[i] <= {side_out[(2-i)*FW +: FW], FW'(0)}
                 + drf_pkg::UNIT_NUM_W'(len >> 1);
      end
      den5 <= len;
      flg5 <= side_out[SIDE_W-1 -: 4];
    end
  end

  drf_delay #(.W(4), .D(drf_pkg::QUO_W)) u_flg (
    .clk(clk), .en(en), .din(flg5), .dout(flg_q)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    drf_div #(
      .NUM_W(drf_pkg::UNIT_NUM_W), .DEN_W(drf_pkg::ROOT_W), .Q_W(drf_pkg::QUO_W)
    ) u_div (
      .clk(clk), .en(en), .num(num5[i]), .den(den5), .quo(quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        unit[i] <= flg_q[i] ? -drf_pkg::UNIT_W'(quo[i]) : drf_pkg::UNIT_W'(quo[i]);
      end
      nz <= flg_q[3];
    end
  end

endmodule

// ----- rtl/dielectric_refraction_fresnel_core.sv -----
// Top level of the refraction and Schlick reflectance pipeline.
// Depends on drf_pkg, drf_delay, drf_isqrt, drf_div and drf_unitize.
//
// Channel  Direction  Handshake            Beat
// in       input      in_valid / in_stall  dir, norm, eta_ratio
// out      output     out_valid / out_stall refr, can_refract, reflectance, degenerate
//
// One beat is accepted every cycle while in_stall is low.
// Each beat passes through two 31-stage square root pipelines and a 31-stage divider in series.
// Reset clears only the valid bits of the pipeline.
// A stalled result freezes every stage, and in_stall is raised for that cycle.
module dielectric_refraction_fresnel_core #(
  parameter int COMPONENT_WIDTH = drf_pkg::DEF_COMPONENT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0]  dir_x,
  input  logic signed [COMPONENT_WIDTH-1:0]  dir_y,
  input  logic signed [COMPONENT_WIDTH-1:0]  dir_z,
  input  logic signed [COMPONENT_WIDTH-1:0]  norm_x,
  input  logic signed [COMPONENT_WIDTH-1:0]  norm_y,
  input  logic signed [COMPONENT_WIDTH-1:0]  norm_z,
  input  logic [15:0]                        eta_ratio,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [drf_pkg::OUT_W-1:0]   refr_x,
  output logic signed [drf_pkg::OUT_W-1:0]   refr_y,
  output logic signed [drf_pkg::OUT_W-1:0]   refr_z,
  output logic                               can_refract,
  output logic [drf_pkg::OUT_W-1:0]          reflectance,
  output logic                               degenerate
);

  localparam int UW = drf_pkg::UNIT_W;
  localparam int L0 = drf_pkg::UNIT_LAT;
  localparam int RT = drf_pkg::ROOT_W;
  localparam int LAT = L0 + 10 + RT;
  localparam logic signed [71:0] ONE72 = 72'sd1073741824;
  localparam logic [30:0] ONE31 = 31'd1073741824;
  localparam logic [61:0] HALF = 62'd536870912;
  localparam logic [63:0] ONE60 = 64'd1 << 60;

  function automatic logic signed [71:0] rshr(input logic signed [71:0] a, input int s);
    logic [71:0] m;
    m = a[71] ? 72'(-a) : 72'(a);
    m = (m + (72'd1 << (s - 1))) >> s;
    return a[71] ? -$signed(m) : $signed(m);
  endfunction

  logic adv;
  logic [LAT-1:0] vld;

  assign adv       = !vld[LAT-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [COMPONENT_WIDTH-1:0] dvec [3];
  logic signed [COMPONENT_WIDTH-1:0] nvec [3];
  logic signed [UW-1:0] ud [3];
  logic signed [UW-1:0] un [3];
  logic nz_d, nz_n;

  assign dvec[0] = dir_x;
  assign dvec[1] = dir_y;
  assign dvec[2] = dir_z;
  assign nvec[0] = norm_x;
  assign nvec[1] = norm_y;
  assign nvec[2] = norm_z;

  drf_unitize #(.CW(COMPONENT_WIDTH)) u_dir (
    .clk(clk), .en(adv), .vec(dvec), .unit(ud), .nz(nz_d)
  );

  drf_unitize #(.CW(COMPONENT_WIDTH)) u_norm (
    .clk(clk), .en(adv), .vec(nvec), .unit(un), .nz(nz_n)
  );

  // Schlick base reflectance, computed straight from the input beat.
  logic [15:0] snum;
  logic [16:0] sden;
  logic [46:0] sdiv;
  logic [16:0] sden1;
  logic [drf_pkg::QUO_W-1:0] rq;
  logic [30:0] r0_33;
  logic [30:0] r0_d;

  always_comb begin
    snum = (eta_ratio >= 16'd4096) ? 16'(eta_ratio - 16'd4096) : 16'(16'd4096 - eta_ratio);
    sden = 17'd4096 + 17'(eta_ratio);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdiv  <= {1'b0, snum, 30'd0} + 47'(sden >> 1);
      sden1 <= sden;
      r0_33 <= 31'((62'(rq) * 62'(rq) + HALF) >> 30);
    end
  end

  drf_div #(.NUM_W(47), .DEN_W(17), .Q_W(drf_pkg::QUO_W)) u_rdiv (
    .clk(clk), .en(adv), .num(sdiv), .den(sden1), .quo(rq)
  );

  drf_delay #(.W(31), .D(L0 + 6 - drf_pkg::QUO_W - 2)) u_r0 (
    .clk(clk), .en(adv), .din(r0_33), .dout(r0_d)
  );

  logic [15:0] eta_d;
  drf_delay #(.W(16), .D(L0 + 4)) u_eta (
    .clk(clk), .en(adv), .din(eta_ratio), .dout(eta_d)
  );

  logic [3*UW-1:0] ud_p, ud3_p, un_p, un2_p, unf_p;
  logic signed [UW-1:0] ud3 [3];
  logic signed [UW-1:0] un2 [3];
  logic signed [UW-1:0] unf [3];

  assign ud_p = {ud[0], ud[1], ud[2]};
  assign un_p = {un[0], un[1], un[2]};

  drf_delay #(.W(3*UW), .D(3)) u_ud (
    .clk(clk), .en(adv), .din(ud_p), .dout(ud3_p)
  );
  drf_delay #(.W(3*UW), .D(2)) u_un (
    .clk(clk), .en(adv), .din(un_p), .dout(un2_p)
  );
  drf_delay #(.W(3*UW), .D(RT + 6)) u_unf (
    .clk(clk), .en(adv), .din(un2_p), .dout(unf_p)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ud3[i] = $signed(ud3_p[(2-i)*UW +: UW]);
      un2[i] = $signed(un2_p[(2-i)*UW +: UW]);
      unf[i] = $signed(unf_p[(2-i)*UW +: UW]);
    end
  end

  logic deg_f;
  drf_delay #(.W(1), .D(RT + 9)) u_deg (
    .clk(clk), .en(adv), .din(!(nz_d && nz_n)), .dout(deg_f)
  );

  logic signed [63:0] pd1 [3];
  logic signed [33:0] cos2;
  logic signed [65:0] mc3 [3];
  logic [30:0] x3, x4r, x5r;
  logic signed [36:0] s4 [3];
  logic [30:0] x2_4, x4_5, x5_6;
  logic signed [53:0] e5 [3];
  logic signed [31:0] perp6 [3];
  logic [30:0] pm6 [3];
  logic [2:0] tirc6;
  logic [61:0] sq7 [3];
  logic tir7;
  logic [61:0] rp7;
  logic [30:0] r0_7;
  logic tir8;
  logic [RT*2-1:0] arg8;
  logic [15:0] refl8;
  logic [RT-1:0] sqr;
  logic signed [63:0] np9 [3];
  logic [3*32-1:0] perp_p, perpf_p;
  logic [16:0] tr_f;

  always_ff @(posedge clk) begin
    logic signed [65:0] dsum;
    logic signed [71:0] cneg;
    logic signed [71:0] pv;
    logic [63:0] ss;
    logic [31:0] rf;
    logic [31:0] r15;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pd1[i] <= 64'(ud[i]) * 64'(un[i]);
      end
      dsum = 66'(pd1[0]) + 66'(pd1[1]) + 66'(pd1[2]);
      cneg = -rshr(72'(dsum), 30);
      cos2 <= (cneg > ONE72) ? 34'sd1073741824 : 34'(cneg);

      for (int i = 0; i < 3; i++) begin
        mc3[i] <= 66'(un2[i]) * 66'(cos2);
      end
      x3 <= (cos2 < 0) ? ONE31 : 31'(ONE31 - 31'(cos2));

      for (int i = 0; i < 3; i++) begin
        s4[i] <= 37'(ud3[i]) + 37'(rshr(72'(mc3[i]), 30));
      end
      x2_4 <= 31'((62'(x3) * 62'(x3) + HALF) >> 30);
      x4r  <= x3;

      for (int i = 0; i < 3; i++) begin
        e5[i] <= 54'(s4[i]) * 54'($signed({1'b0, eta_d}));
      end
      x4_5 <= 31'((62'(x2_4) * 62'(x2_4) + HALF) >> 30);
      x5r  <= x4r;

      for (int i = 0; i < 3; i++) begin
        pv = rshr(72'(e5[i]), 12);
        perp6[i] <= 32'(pv);
        tirc6[i] <= (pv > ONE72) || (pv < -ONE72);
        pm6[i]   <= pv[71] ? 31'(-pv) : 31'(pv);
      end
      x5_6 <= 31'((62'(x4_5) * 62'(x5r) + HALF) >> 30);

      for (int i = 0; i < 3; i++) begin
        sq7[i] <= 62'(pm6[i]) * 62'(pm6[i]);
      end
      tir7 <= |tirc6;
      rp7  <= 62'(ONE31 - r0_d) * 62'(x5_6);
      r0_7 <= r0_d;

      ss = 64'(sq7[0]) + 64'(sq7[1]) + 64'(sq7[2]);
      tir8 <= tir7 || (ss > ONE60);
      arg8 <= (RT*2)'(ONE60 - ss);
      rf  = 32'(r0_7) + 32'((rp7 + HALF) >> 30);
      r15 = (rf + 32'd16384) >> 15;
      refl8 <= (r15 > 32'd32768) ? 16'd32768 : 16'(r15);

      for (int i = 0; i < 3; i++) begin
        np9[i] <= 64'(unf[i]) * 64'($signed({1'b0, sqr}));
      end
    end
  end

  drf_isqrt #(.IN_W(RT*2)) u_tsq (
    .clk(clk), .en(adv), .rad(arg8), .root(sqr)
  );

  assign perp_p = {perp6[0], perp6[1], perp6[2]};
  drf_delay #(.W(3*32), .D(RT + 3)) u_perp (
    .clk(clk), .en(adv), .din(perp_p), .dout(perpf_p)
  );
  drf_delay #(.W(17), .D(RT + 1)) u_tir (
    .clk(clk), .en(adv), .din({tir8, refl8}), .dout(tr_f)
  );

  always_ff @(posedge clk) begin
    logic signed [71:0] v [3];
    logic signed [15:0] o [3];
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        v[i] = rshr(72'($signed(perpf_p[(2-i)*32 +: 32])) - rshr(72'(np9[i]), 30), 16);
        if (v[i] > 72'sd16384) begin
          o[i] = 16'sd16384;
        end else if (v[i] < -72'sd16384) begin
          o[i] = -16'sd16384;
        end else begin
          o[i] = 16'(v[i]);
        end
      end
      degenerate <= deg_f;
      if (deg_f || tr_f[16]) begin
        refr_x      <= '0;
        refr_y      <= '0;
        refr_z      <= '0;
        can_refract <= 1'b0;
        reflectance <= deg_f ? 16'd0 : 16'd32768;
      end else begin
        refr_x      <= o[0];
        refr_y      <= o[1];
        refr_z      <= o[2];
        can_refract <= 1'b1;
        reflectance <= tr_f[15:0];
      end
    end
  end

endmodule
